>>> hw/rtl/rfr_pkg.sv
`timescale 1ns / 1ps

package rfr_pkg;

   // longest frame in bytes, header and check byte included
   localparam int MAX_FRAME = 64;

   // byte position counter covers 0 .. MAX_FRAME-1
   localparam int POS_W = $clog2(MAX_FRAME);

   // two header bytes and the length byte; the length value counts body and check byte
   localparam int LEN_OVERHEAD = 3;

   localparam logic [7:0] HDR_FIRST  = 8'hAA;
   localparam logic [7:0] HDR_SECOND = 8'hBB;

   localparam logic [31:0] ID_NEW_BODY = 32'h0001_4115;
   localparam logic [15:0] ID_OLD_BODY = 16'h4115;

   localparam logic [7:0] BODY_LEN_NEW  = 8'd4;
   localparam logic [7:0] BODY_LEN_OLD  = 8'd2;
   localparam logic [7:0] BODY_LEN_CARD = 8'd5;

   // receiver positions with a meaning of their own
   localparam logic [POS_W-1:0] POS_HUNT   = POS_W'(0);
   localparam logic [POS_W-1:0] POS_SECOND = POS_W'(1);
   localparam logic [POS_W-1:0] POS_LENGTH = POS_W'(2);
   localparam logic [POS_W-1:0] POS_BODY   = POS_W'(3);

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_IDX_CARD_CODE = 1'b0;
   localparam logic [7:0] CARD_CODE_RESET = 8'h41;

   typedef enum logic [1:0] {
      KIND_UNKNOWN = 2'd0,
      KIND_OLD     = 2'd1,
      KIND_NEW     = 2'd2
   } kind_type;

   // one result beat
   typedef struct packed {
      logic        frame_good;
      logic        check_failed;
      logic        frame_ok_seen;
      logic [1:0]  module_kind;
      logic        new_card;
      logic [31:0] card_id;
      logic [31:0] previous_card_id;
      logic [31:0] card_time;
   } result_type;

endpackage

>>> hw/rtl/rfr_req_if.sv
`timescale 1ns / 1ps

interface rfr_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  rx_byte;
   logic [31:0] time_stamp;

   modport source (output valid, rx_byte, time_stamp, input ready);
   modport sink (input valid, rx_byte, time_stamp, output ready);
endinterface

>>> hw/rtl/rfr_rsp_if.sv
`timescale 1ns / 1ps

interface rfr_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_good;
   logic        check_failed;
   logic        frame_ok_seen;
   logic [1:0]  module_kind;
   logic        new_card;
   logic [31:0] card_id;
   logic [31:0] previous_card_id;
   logic [31:0] card_time;

   modport source (
      output valid, frame_good, check_failed, frame_ok_seen, module_kind, new_card,
             card_id, previous_card_id, card_time,
      input  ready
   );
   modport sink (
      input  valid, frame_good, check_failed, frame_ok_seen, module_kind, new_card,
             card_id, previous_card_id, card_time,
      output ready
   );
endinterface

>>> hw/rtl/rfid_frame_receiver_top.sv
`timescale 1ns / 1ps

// byte-serial frame receiver for a card reader link
//
// req_bus carries one received byte and the current time base per beat; rsp_bus
// returns exactly one result beat for every request beat, in order. Both use a
// valid/ready handshake. The csr port holds the card report code (word 0).
//
// a request beat is captured in an input register; on the next cycle in which
// the result register is free or being emptied, the frame logic walks that
// byte and loads the result register. With no stall the byte passes the input
// register and then the result register before its result is valid on rsp_bus;
// one byte per cycle is sustained when rsp_bus is ready.
//
// when rsp_bus stalls, the result register holds its beat and one more byte
// waits in the input register; req_bus ready then drops until the result is
// taken. Reset clears the receiver to header hunting, module type unknown,
// card ids and time zero, card report code 0x41, and both registers empty.
module rfid_frame_receiver_top
   import rfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   rfr_req_if.sink               req_bus,
   rfr_rsp_if.source             rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic        in_vld_ff, in_vld_in;
   logic [7:0]  in_byte_ff;
   logic [31:0] in_time_ff;
   logic        out_vld_ff, out_vld_in;
   result_type  out_ff;
   result_type  step_result;
   logic        advance;
   logic        req_beat;
   logic [7:0]  card_code;

   rfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .card_code   (card_code)
   );

   rfr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .rx_byte    (in_byte_ff),
      .time_stamp (in_time_ff),
      .card_code  (card_code),
      .result     (step_result)
   );

   // pipeline flow
   assign advance       = in_vld_ff && (!out_vld_ff || rsp_bus.ready);
   assign req_bus.ready = !in_vld_ff || advance;
   assign req_beat      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_beat) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_vld_in = 1'b0;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_byte_ff <= req_bus.rx_byte;
         in_time_ff <= req_bus.time_stamp;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_bus.valid            = out_vld_ff;
   assign rsp_bus.frame_good       = out_ff.frame_good;
   assign rsp_bus.check_failed     = out_ff.check_failed;
   assign rsp_bus.frame_ok_seen    = out_ff.frame_ok_seen;
   assign rsp_bus.module_kind      = out_ff.module_kind;
   assign rsp_bus.new_card         = out_ff.new_card;
   assign rsp_bus.card_id          = out_ff.card_id;
   assign rsp_bus.previous_card_id = out_ff.previous_card_id;
   assign rsp_bus.card_time        = out_ff.card_time;

   // a stalled result keeps the waiting byte in the input register
   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && out_vld_ff && !rsp_bus.ready) |=> in_vld_ff)
      else $error("input byte lost during result stall");

   // every advance produces a result beat on the next cycle
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_vld_ff)
      else $error("processed byte produced no result");

   // a result is never overwritten before it is taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_bus.ready) |-> !advance)
      else $error("result register overwritten while stalled");

endmodule

>>> hw/rtl/rfr_csr.sv
`timescale 1ns / 1ps

module rfr_csr
   import rfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [7:0]            card_code
);

   logic [7:0] card_code_ff;
   logic [7:0] card_code_in;
   logic       sel_card_code;
   logic       wr_beat;

   // register index is the word address, byte lanes ignored
   assign sel_card_code = (csr_paddr[CSR_ADDR_W-1] == REG_IDX_CARD_CODE);
   assign wr_beat       = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready    = 1'b1;

   // write decode
   always_comb begin
      card_code_in = card_code_ff;
      if (wr_beat && sel_card_code) begin
         card_code_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         card_code_ff <= CARD_CODE_RESET;
      end else begin
         card_code_ff <= card_code_in;
      end
   end

   // read mux
   always_comb begin
      csr_prdata = '0;
      if (sel_card_code) begin
         csr_prdata = {{(CSR_DATA_W-8){1'b0}}, card_code_ff};
      end
   end

   assign card_code = card_code_ff;

endmodule

>>> hw/rtl/rfr_parser.sv
`timescale 1ns / 1ps

module rfr_parser
   import rfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step_en,
   input  logic [7:0]  rx_byte,
   input  logic [31:0] time_stamp,
   input  logic [7:0]  card_code,
   output result_type  result
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       xor_ff, xor_in;
   logic [39:0]      head_ff, head_in;
   kind_type         kind_ff, kind_in;
   logic             ok_ff, ok_in;
   logic [31:0]      latest_ff, latest_in;
   logic [31:0]      older_ff, older_in;
   logic [31:0]      time_ff, time_in;
   logic             good, bad, card;
   logic [8:0]       len_sum;
   logic [8:0]       last_body;
   logic [7:0]       body_len;

   assign len_sum   = {1'b0, rx_byte} + 9'(LEN_OVERHEAD);
   assign last_body = {1'b0, len_ff} + 9'd1;
   assign body_len  = len_ff - 8'd1;

   // frame walk for one byte
   always_comb begin
      pos_in    = pos_ff;
      len_in    = len_ff;
      xor_in    = xor_ff;
      head_in   = head_ff;
      kind_in   = kind_ff;
      ok_in     = ok_ff;
      latest_in = latest_ff;
      older_in  = older_ff;
      time_in   = time_ff;
      good      = 1'b0;
      bad       = 1'b0;
      card      = 1'b0;
      priority if (pos_ff == POS_HUNT) begin
         if (rx_byte == HDR_FIRST) begin
            pos_in = POS_SECOND;
         end
      end else if (pos_ff == POS_SECOND) begin
         pos_in = (rx_byte == HDR_SECOND) ? POS_LENGTH : POS_HUNT;
      end else if (pos_ff == POS_LENGTH) begin
         len_in  = rx_byte;
         xor_in  = rx_byte;
         head_in = '0;
         // zero length and oversize frames are dropped silently
         if (rx_byte == 8'd0 || len_sum > 9'(MAX_FRAME)) begin
            pos_in = POS_HUNT;
         end else begin
            pos_in = POS_BODY;
         end
      end else if (9'(pos_ff) <= last_body) begin
         xor_in  = xor_ff ^ rx_byte;
         head_in = {head_ff[31:0], rx_byte};
         pos_in  = pos_ff + POS_W'(1);
      end else begin
         // check byte
         pos_in = POS_HUNT;
         if (rx_byte == xor_ff) begin
            good  = 1'b1;
            ok_in = 1'b1;
            if (kind_ff == KIND_UNKNOWN) begin
               if (body_len == BODY_LEN_NEW && head_ff[31:0] == ID_NEW_BODY) begin
                  kind_in = KIND_NEW;
               end else if (body_len == BODY_LEN_OLD && head_ff[15:0] == ID_OLD_BODY) begin
                  kind_in = KIND_OLD;
               end
            end else if (body_len == BODY_LEN_CARD && head_ff[39:32] == card_code) begin
               older_in  = latest_ff;
               latest_in = head_ff[31:0];
               time_in   = time_stamp;
               card      = 1'b1;
            end
         end else begin
            bad = 1'b1;
         end
      end
   end

   // receiver state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_HUNT;
         len_ff    <= '0;
         xor_ff    <= '0;
         head_ff   <= '0;
         kind_ff   <= KIND_UNKNOWN;
         ok_ff     <= 1'b0;
         latest_ff <= '0;
         older_ff  <= '0;
         time_ff   <= '0;
      end else if (step_en) begin
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         xor_ff    <= xor_in;
         head_ff   <= head_in;
         kind_ff   <= kind_in;
         ok_ff     <= ok_in;
         latest_ff <= latest_in;
         older_ff  <= older_in;
         time_ff   <= time_in;
      end
   end

   // result reflects the state after this byte
   always_comb begin
      result.frame_good       = good;
      result.check_failed     = bad;
      result.frame_ok_seen    = ok_in;
      result.module_kind      = kind_in;
      result.new_card         = card;
      result.card_id          = latest_in;
      result.previous_card_id = older_in;
      result.card_time        = time_in;
   end

   // a card report is always a good frame
   a_card_is_good: assert property (@(posedge clock) disable iff (reset)
      card |-> good)
      else $error("card report without good check");

   // once identified, the module type stays
   a_kind_sticky: assert property (@(posedge clock) disable iff (reset)
      (kind_ff != KIND_UNKNOWN) |=> (kind_ff == $past(kind_ff)))
      else $error("module type changed after identification");

   // inside a frame the position never passes the check byte
   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      (pos_ff >= POS_BODY) |-> (9'(pos_ff) <= last_body + 9'd1))
      else $error("byte position ran past the check byte");

   // the good flag is set whenever a good frame completes
   a_ok_follows: assert property (@(posedge clock) disable iff (reset)
      (step_en && good) |=> ok_ff)
      else $error("good frame did not set the sticky flag");

endmodule
